// ===== sv/array_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication
`define APQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apq assertion failed");

// Next-cycle implication
`define APQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apq assertion failed");

`endif

// ===== sv/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// Shared widths, request/response codes and cell types of the priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 16;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  // Request kinds (code 3 is a no-op)
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast to every cell
  typedef struct packed {
    logic insert;   // sorted insert of the new entry
    logic shift;    // pop head, each cell takes its right neighbor, the tail empties
  } cell_ctrl_t;

endpackage

// ===== sv/apq_req_if.sv =====
// ----------------------------------------------------------------------------
// apq_req_if
// Request channel: valid/ready handshake with mode, value and priority.
// ----------------------------------------------------------------------------
interface apq_req_if;
  import apq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] item_value;
  logic [PRIO_W-1:0]         item_priority;

  modport source (output valid, mode, item_value, item_priority, input ready);
  modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

// ===== sv/apq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// apq_rsp_if
// Response channel: valid/ready handshake with status, value and priority.
// ----------------------------------------------------------------------------
interface apq_rsp_if;
  import apq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic [PRIO_W-1:0]         out_priority;

  modport source (output valid, status, out_value, out_priority, input ready);
  modport sink   (input valid, status, out_value, out_priority, output ready);
endinterface

// ===== sv/apq_cell.sv =====
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted queue. Holds an entry and an occupied flag, and on
// each insert or pop takes its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module apq_cell (
  input  logic                clk,
  input  logic                rst,
  input  apq_pkg::cell_ctrl_t ctrl,
  input  apq_pkg::entry_t     new_entry,
  input  apq_pkg::entry_t     left_entry,
  input  logic                left_occ,
  input  logic                left_after,
  input  apq_pkg::entry_t     right_entry,
  input  logic                right_occ,
  output apq_pkg::entry_t     entry,
  output logic                occ,
  output logic                after
);
  import apq_pkg::*;

  // New entry sorts below this one: ties keep arrival order
  assign after = occ && (entry.prio >= new_entry.prio);

  // Occupied flag
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.insert) begin
      occ <= left_occ;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!after) begin
        entry <= left_after ? new_entry : left_entry;
      end
    end else if (ctrl.shift) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== sv/array_priority_queue.sv =====
// Response: registered, valid in the cycle after its request is taken.
// Throughput: one request per cycle while responses are taken; an insert that
//   finds room or a delete that finds an entry updates the cell chain in the cycle in which it is accepted.
// Reset: rst (synchronous) empties the queue and drops any pending response;
//   no clearing pass is needed, the cells' payload is never read unoccupied.
// ----------------------------------------------------------------------------
// array_priority_queue
// Bounded priority queue built as a chain of sorted cells; the head always
// holds the earliest entry of the highest priority.
// ----------------------------------------------------------------------------
`include "array_priority_queue_defines.svh"

module array_priority_queue #(
  parameter int QUEUE_DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  apq_req_if.sink   req,
  apq_rsp_if.source rsp
);
  import apq_pkg::*;

  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] after;
  cell_ctrl_t             ctrl;
  entry_t                 new_entry;

  logic                      fire;
  logic                      full;
  logic                      empty;
  logic                      rsp_valid;
  logic [STATUS_W-1:0]       rsp_status;
  logic signed [VALUE_W-1:0] rsp_value;
  logic [PRIO_W-1:0]         rsp_prio;

  // Handshake and occupancy
  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = occ[QUEUE_DEPTH-1];
  assign empty     = !occ[0];

  assign new_entry.value = req.item_value;
  assign new_entry.prio  = req.item_priority;

  // Broadcast control
  always_comb begin
    ctrl.insert = fire && (req.mode == MODE_INSERT) && !full;
    ctrl.shift  = fire && (req.mode == MODE_DELETE) && !empty;
  end

  // Cell chain: cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t l_entry;
    logic   l_occ;
    logic   l_after;
    entry_t r_entry;
    logic   r_occ;

    if (i == 0) begin : g_head
      assign l_entry = new_entry;
      assign l_occ   = 1'b1;
      assign l_after = 1'b1;
    end else begin : g_body
      assign l_entry = entries[i-1];
      assign l_occ   = occ[i-1];
      assign l_after = after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_entry = entries[i];
      assign r_occ   = 1'b0;
    end else begin : g_mid
      assign r_entry = entries[i+1];
      assign r_occ   = occ[i+1];
    end

    apq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (l_entry),
      .left_occ    (l_occ),
      .left_after  (l_after),
      .right_entry (r_entry),
      .right_occ   (r_occ),
      .entry       (entries[i]),
      .occ         (occ[i]),
      .after       (after[i])
    );
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload, taken from the head before the chain moves
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status <= ST_OK;
      rsp_value  <= '0;
      rsp_prio   <= '0;
      case (req.mode)
        MODE_INSERT: begin
          if (full) begin
            rsp_status <= ST_FULL;
          end
        end
        MODE_PEEK: begin
          if (empty) begin
            rsp_status <= ST_EMPTY;
          end else begin
            rsp_prio <= entries[0].prio;
          end
        end
        MODE_DELETE: begin
          if (empty) begin
            rsp_status <= ST_EMPTY;
          end else begin
            rsp_prio  <= entries[0].prio;
            rsp_value <= entries[0].value;
          end
        end
        default: begin
          rsp_status <= ST_OK;
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.out_value    = rsp_value;
  assign rsp.out_priority = rsp_prio;

  // Checks
  `APQ_ASSERT_SAME(a_occ_prefix, 1'b1, ((occ >> 1) & ~occ) == '0)
  `APQ_ASSERT_SAME(a_head_sorted, occ[1], entries[0].prio >= entries[1].prio)
  `APQ_ASSERT_NEXT(a_insert_grows, ctrl.insert, $countones(occ) == $past($countones(occ)) + 1)
  `APQ_ASSERT_NEXT(a_pop_shrinks, ctrl.shift, $countones(occ) + 1 == $past($countones(occ)))
  `APQ_ASSERT_SAME(a_no_both, 1'b1, !(ctrl.insert && ctrl.shift))

endmodule
